### hw/rtl/abl_pkg.sv
// Package for the address blocklist unit: sizes, request kinds, status codes
// and the time constants. No dependencies.
package abl_pkg;

    localparam int MAX_ENTRIES_DEF = 64;

    localparam logic [2:0] KIND_ADD    = 3'd0;
    localparam logic [2:0] KIND_REMOVE = 3'd1;
    localparam logic [2:0] KIND_CHECK  = 3'd2;
    localparam logic [2:0] KIND_EXPIRE = 3'd3;
    localparam logic [2:0] KIND_GET    = 3'd4;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NOTFOUND = 2'd1;
    localparam logic [1:0] STATUS_FULL     = 2'd2;

    localparam logic [31:0] PERM_STAMP = 32'hffff_ffff;

    // Minutes are rounded up: (seconds + 59) / 60.
    localparam logic [6:0]  SEC_PER_MIN  = 7'd60;
    localparam logic [32:0] ROUND_UP_SEC = 33'd59;
    // ceil(2^35 / 15): x / 60 is (x >> 2) * MIN_RECIP >> 35 for x below 2^33.
    localparam logic [31:0] MIN_RECIP    = 32'h8888_8889;

endpackage

### hw/rtl/abl_store.sv
// Entry memory of the blocklist: address and expiry arrays with one write
// port and one registered read port. Uses abl_pkg.
module abl_store
    import abl_pkg::*;
#(
    parameter int DEPTH = MAX_ENTRIES_DEF,
    parameter int AW    = 6
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [31:0]   wr_key,
    input  logic [31:0]   wr_exp,
    input  logic [AW-1:0] rd_addr,
    output logic [31:0]   rd_key,
    output logic [31:0]   rd_exp
);

    logic [31:0] key_mem [DEPTH];
    logic [31:0] exp_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
            exp_mem[wr_addr] <= wr_exp;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_key <= key_mem[rd_addr];
        rd_exp <= exp_mem[rd_addr];
    end

endmodule

### hw/rtl/abl_div.sv
// Converts a remaining time in seconds into minutes, rounded up, by a reciprocal
// multiplication; the sum is registered, then the product. Uses abl_pkg.
module abl_div
    import abl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] seconds,
    output logic        done,
    output logic [26:0] minutes
);

    logic [32:0] sum_reg, sum_next;
    logic [62:0] prod_reg, prod_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    always_comb
    begin
        sum_next  = sum_reg;
        prod_next = prod_reg;
        busy_next = 1'b0;
        done_next = 1'b0;
        if (start)
        begin
            sum_next  = {1'b0, seconds} + ROUND_UP_SEC;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // Dividing by 4 first leaves a division by 15 of a 31-bit value.
            prod_next = 63'(sum_reg[32:2]) * 63'(MIN_RECIP);
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg  <= sum_next;
        prod_reg <= prod_next;
    end

    assign done    = done_reg;
    assign minutes = prod_reg[61:35];

endmodule

### hw/rtl/address_blocklist_with_expiry_unit.sv
// Top level of the address blocklist with expiry: request sequencer around
// the entry memory (abl_store) and the minutes divider (abl_div). Uses abl_pkg.
//
// Requests enter on in_valid/in_stall and results leave on out_valid/out_stall;
// a transfer happens on a clock edge with valid high and stall low. Every
// request gives exactly one result, which carries the entry count after it.
// Entries are kept in one memory sorted by expiry, earliest first, and one
// read and one write port serve every scan and shift, one entry a cycle.
// Add takes a key scan, a shift down if present, a position scan, a shift up
// if needed and a write, unless full. Remove and expire each take a scan and,
// when entries go, a shift. Check takes a key scan and, for a non-permanent
// entry, the divider for the minutes. Get reads the entry at its position.
// The block accepts one request at a time; in_stall is high while a request
// is in work. A finished result sits in the output register while the next
// request is taken; if the receiver still stalls when the following result
// is ready, the sequencer waits. Reset empties the table at once; the memory
// needs no clearing since only entries below the count are ever used.
module address_blocklist_with_expiry_unit
    import abl_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  kind,
    input  logic [31:0] ip_address,
    input  logic [30:0] duration_seconds,
    input  logic [31:0] now_seconds,
    input  logic [5:0]  entry_position,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic        hit,
    output logic [26:0] minutes_left,
    output logic        is_permanent,
    output logic [31:0] entry_ip,
    output logic [31:0] entry_expiry,
    output logic        entry_valid,
    output logic [6:0]  entries_in_use
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_SHIFT, ST_PUT, ST_GET, ST_GETD, ST_DIV, ST_OUT
    } state_t;

    typedef enum logic [1:0] {SM_KEY, SM_INS, SM_EXP} scan_t;

    state_t        state_reg, state_next;
    scan_t         smode_reg, smode_next;
    logic [2:0]    kind_reg, kind_next;
    logic [31:0]   ip_reg, ip_next;
    logic [31:0]   now_reg, now_next;
    logic [31:0]   stamp_reg, stamp_next;
    logic [5:0]    pos_reg, pos_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] addr_reg, addr_next;
    logic          dv_reg, dv_next;
    logic [CW-1:0] dpos_reg, dpos_next;
    logic [CW-1:0] left_reg, left_next;
    logic [CW-1:0] off_reg, off_next;
    logic          up_reg, up_next;
    logic [CW-1:0] ins_reg, ins_next;

    logic [1:0]    r_status_reg, r_status_next;
    logic          r_hit_reg, r_hit_next;
    logic          r_perm_reg, r_perm_next;
    logic [31:0]   r_eip_reg, r_eip_next;
    logic [31:0]   r_eexp_reg, r_eexp_next;
    logic          r_ev_reg, r_ev_next;
    logic [26:0]   r_min_reg, r_min_next;

    logic          out_valid_reg, out_valid_next;
    logic [1:0]    status_reg, status_next;
    logic          hit_reg, hit_next;
    logic [26:0]   min_reg, min_next;
    logic          perm_reg, perm_next;
    logic [31:0]   eip_reg, eip_next;
    logic [31:0]   eexp_reg, eexp_next;
    logic          ev_reg, ev_next;
    logic [6:0]    used_reg, used_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_key, wr_exp;
    logic [AW-1:0] rd_addr;
    logic [31:0]   rd_key, rd_exp;

    logic          div_start, div_done;
    logic [31:0]   div_sec;
    logic [26:0]   div_min;

    logic          match;
    logic          scan_end;
    logic          scan_found;
    logic [CW-1:0] scan_pos;
    logic          accept;

    abl_store #(.DEPTH(MAX_ENTRIES), .AW(AW)) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_key  (wr_key),
        .wr_exp  (wr_exp),
        .rd_addr (rd_addr),
        .rd_key  (rd_key),
        .rd_exp  (rd_exp)
    );

    abl_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .seconds (div_sec),
        .done    (div_done),
        .minutes (div_min)
    );

    assign accept = in_valid && (state_reg == ST_IDLE);

    always_comb
    begin
        case (smode_reg)
            SM_KEY:  match = (rd_key == ip_reg);
            SM_INS:  match = (stamp_reg < rd_exp);
            SM_EXP:  match = !(rd_exp < now_reg);
            default: match = 1'b0;
        endcase
    end

    // A scan stops at the first matching entry, or past the last one with
    // the position equal to the count.
    assign scan_found = dv_reg && match;
    assign scan_end   = scan_found || (addr_reg >= cnt_reg);
    assign scan_pos   = scan_found ? dpos_reg : cnt_reg;

    always_comb
    begin
        state_next     = state_reg;
        smode_next     = smode_reg;
        kind_next      = kind_reg;
        ip_next        = ip_reg;
        now_next       = now_reg;
        stamp_next     = stamp_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        addr_next      = addr_reg;
        dv_next        = 1'b0;
        dpos_next      = dpos_reg;
        left_next      = left_reg;
        off_next       = off_reg;
        up_next        = up_reg;
        ins_next       = ins_reg;
        r_status_next  = r_status_reg;
        r_hit_next     = r_hit_reg;
        r_perm_next    = r_perm_reg;
        r_eip_next     = r_eip_reg;
        r_eexp_next    = r_eexp_reg;
        r_ev_next      = r_ev_reg;
        r_min_next     = r_min_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        hit_next       = hit_reg;
        min_next       = min_reg;
        perm_next      = perm_reg;
        eip_next       = eip_reg;
        eexp_next      = eexp_reg;
        ev_next        = ev_reg;
        used_next      = used_reg;
        wr_en          = 1'b0;
        wr_addr        = dpos_reg[AW-1:0];
        wr_key         = rd_key;
        wr_exp         = rd_exp;
        rd_addr        = addr_reg[AW-1:0];
        div_start      = 1'b0;
        div_sec        = rd_exp - now_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    kind_next     = kind;
                    ip_next       = ip_address;
                    now_next      = now_seconds;
                    stamp_next    = (duration_seconds == '0) ? PERM_STAMP
                                    : now_seconds + {1'b0, duration_seconds};
                    pos_next      = entry_position;
                    r_status_next = STATUS_OK;
                    r_hit_next    = 1'b0;
                    r_perm_next   = 1'b0;
                    r_eip_next    = '0;
                    r_eexp_next   = '0;
                    r_ev_next     = 1'b0;
                    r_min_next    = '0;
                    addr_next     = '0;
                    case (kind)
                        KIND_ADD, KIND_REMOVE, KIND_CHECK:
                        begin
                            smode_next = SM_KEY;
                            state_next = ST_SCAN;
                        end
                        KIND_EXPIRE:
                        begin
                            smode_next = SM_EXP;
                            state_next = ST_SCAN;
                        end
                        KIND_GET:
                        begin
                            if (16'(entry_position) < 16'(cnt_reg))
                            begin
                                state_next = ST_GET;
                            end
                            else
                            begin
                                r_status_next = STATUS_NOTFOUND;
                                state_next    = ST_OUT;
                            end
                        end
                        default:
                        begin
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (!scan_end)
                begin
                    dv_next   = 1'b1;
                    dpos_next = addr_reg;
                    addr_next = addr_reg + 1'b1;
                end
                else
                begin
                    case (smode_reg)
                        SM_KEY:
                        begin
                            if (!scan_found)
                            begin
                                if (kind_reg == KIND_ADD)
                                begin
                                    if (16'(cnt_reg) >= 16'(MAX_ENTRIES))
                                    begin
                                        r_status_next = STATUS_FULL;
                                        state_next    = ST_OUT;
                                    end
                                    else
                                    begin
                                        smode_next = SM_INS;
                                        addr_next  = '0;
                                    end
                                end
                                else
                                begin
                                    r_status_next = STATUS_NOTFOUND;
                                    state_next    = ST_OUT;
                                end
                            end
                            else if (kind_reg == KIND_CHECK)
                            begin
                                r_hit_next = 1'b1;
                                if (rd_exp == PERM_STAMP)
                                begin
                                    r_perm_next = 1'b1;
                                    state_next  = ST_OUT;
                                end
                                else
                                begin
                                    div_start  = 1'b1;
                                    state_next = ST_DIV;
                                end
                            end
                            else
                            begin
                                // Close the gap left by the matching entry.
                                addr_next  = scan_pos + 1'b1;
                                left_next  = cnt_reg - scan_pos - 1'b1;
                                off_next   = CW'(1);
                                up_next    = 1'b0;
                                state_next = ST_SHIFT;
                            end
                        end
                        SM_INS:
                        begin
                            ins_next = scan_pos;
                            if (scan_pos != cnt_reg)
                            begin
                                addr_next  = cnt_reg - 1'b1;
                                left_next  = cnt_reg - scan_pos;
                                off_next   = CW'(1);
                                up_next    = 1'b1;
                                state_next = ST_SHIFT;
                            end
                            else
                            begin
                                state_next = ST_PUT;
                            end
                        end
                        default:
                        begin
                            // Expired entries form a prefix; drop them all in one shift.
                            if (scan_pos != '0)
                            begin
                                addr_next  = scan_pos;
                                left_next  = cnt_reg - scan_pos;
                                off_next   = scan_pos;
                                up_next    = 1'b0;
                                state_next = ST_SHIFT;
                            end
                            else
                            begin
                                state_next = ST_OUT;
                            end
                        end
                    endcase
                end
            end

            ST_SHIFT:
            begin
                if (dv_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = up_reg ? AW'(dpos_reg + off_reg) : AW'(dpos_reg - off_reg);
                end
                if (left_reg != '0)
                begin
                    dv_next   = 1'b1;
                    dpos_next = addr_reg;
                    addr_next = up_reg ? addr_reg - 1'b1 : addr_reg + 1'b1;
                    left_next = left_reg - 1'b1;
                end
                else if (!dv_reg)
                begin
                    if (up_reg)
                    begin
                        state_next = ST_PUT;
                    end
                    else
                    begin
                        cnt_next = cnt_reg - off_reg;
                        if (kind_reg == KIND_ADD)
                        begin
                            smode_next = SM_INS;
                            addr_next  = '0;
                            state_next = ST_SCAN;
                        end
                        else
                        begin
                            state_next = ST_OUT;
                        end
                    end
                end
            end

            ST_PUT:
            begin
                wr_en      = 1'b1;
                wr_addr    = ins_reg[AW-1:0];
                wr_key     = ip_reg;
                wr_exp     = stamp_reg;
                cnt_next   = cnt_reg + 1'b1;
                state_next = ST_OUT;
            end

            ST_GET:
            begin
                rd_addr    = AW'(pos_reg);
                state_next = ST_GETD;
            end

            ST_GETD:
            begin
                r_eip_next  = rd_key;
                r_eexp_next = rd_exp;
                r_ev_next   = 1'b1;
                r_perm_next = (rd_exp == PERM_STAMP);
                state_next  = ST_OUT;
            end

            ST_DIV:
            begin
                if (div_done)
                begin
                    r_min_next = div_min;
                    state_next = ST_OUT;
                end
            end

            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    status_next    = r_status_reg;
                    hit_next       = r_hit_reg;
                    min_next       = r_min_reg;
                    perm_next      = r_perm_reg;
                    eip_next       = r_eip_reg;
                    eexp_next      = r_eexp_reg;
                    ev_next        = r_ev_reg;
                    used_next      = 7'(cnt_reg);
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            smode_reg     <= SM_KEY;
            cnt_reg       <= '0;
            dv_reg        <= 1'b0;
            left_reg      <= '0;
            up_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            smode_reg     <= smode_next;
            cnt_reg       <= cnt_next;
            dv_reg        <= dv_next;
            left_reg      <= left_next;
            up_reg        <= up_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        ip_reg       <= ip_next;
        now_reg      <= now_next;
        stamp_reg    <= stamp_next;
        pos_reg      <= pos_next;
        addr_reg     <= addr_next;
        dpos_reg     <= dpos_next;
        off_reg      <= off_next;
        ins_reg      <= ins_next;
        r_status_reg <= r_status_next;
        r_hit_reg    <= r_hit_next;
        r_perm_reg   <= r_perm_next;
        r_eip_reg    <= r_eip_next;
        r_eexp_reg   <= r_eexp_next;
        r_ev_reg     <= r_ev_next;
        r_min_reg    <= r_min_next;
        status_reg   <= status_next;
        hit_reg      <= hit_next;
        min_reg      <= min_next;
        perm_reg     <= perm_next;
        eip_reg      <= eip_next;
        eexp_reg     <= eexp_next;
        ev_reg       <= ev_next;
        used_reg     <= used_next;
    end

    assign in_stall       = (state_reg != ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign hit            = hit_reg;
    assign minutes_left   = min_reg;
    assign is_permanent   = perm_reg;
    assign entry_ip       = eip_reg;
    assign entry_expiry   = eexp_reg;
    assign entry_valid    = ev_reg;
    assign entries_in_use = used_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        16'(cnt_reg) <= 16'(MAX_ENTRIES))
        else $error("entry count beyond table size");

    a_put_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PUT) |-> (16'(cnt_reg) < 16'(MAX_ENTRIES)))
        else $error("insert into a full table");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && kind != KIND_GET && kind <= KIND_GET)
        |=> (state_reg == ST_SCAN))
        else $error("request did not start a scan");

    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the check sequence");

endmodule

### tb/tb_address_blocklist_with_expiry_unit.sv
// Self-checking testbench for the address blocklist unit: directed table, then
// random requests checked against a predictor of the expiry-sorted table. Uses abl_pkg.
module tb_address_blocklist_with_expiry_unit;
    import abl_pkg::*;

    localparam int DEPTH = MAX_ENTRIES_DEF;
    localparam int LIMIT = 4000000;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] ip;
        logic [30:0] dur;
        logic [31:0] now;
        logic [5:0]  pos;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        hit;
        logic [26:0] minutes;
        logic        perm;
        logic [31:0] eip;
        logic [31:0] eexp;
        logic        evalid;
        logic [6:0]  used;
    } rsp_t;

    typedef struct {
        req_t r;
        bit   fixed;
        rsp_t want;
    } row_t;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [2:0]  kind = '0;
    logic [31:0] ip_address = '0;
    logic [30:0] duration_seconds = '0;
    logic [31:0] now_seconds = '0;
    logic [5:0]  entry_position = '0;
    logic        out_valid;
    logic        out_stall = 0;
    logic [1:0]  status;
    logic        hit;
    logic [26:0] minutes_left;
    logic        is_permanent;
    logic [31:0] entry_ip;
    logic [31:0] entry_expiry;
    logic        entry_valid;
    logic [6:0]  entries_in_use;

    address_blocklist_with_expiry_unit dut (.*);

    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    logic [31:0] tbl_ip [DEPTH];
    logic [31:0] tbl_exp [DEPTH];
    int          tbl_cnt = 0;
    rsp_t        expected_q [$];
    int          mismatches = 0;
    int          cycles = 0;
    int          send_idle = 11;
    int          recv_idle = 72;
    logic [31:0] ip_pool [8];

    function automatic int find_ip(logic [31:0] a);
        for (int i = 0; i < tbl_cnt; i++)
            if (tbl_ip[i] == a)
                return i;
        return -1;
    endfunction

    function automatic void drop_at(int p);
        for (int i = p; i + 1 < tbl_cnt; i++)
        begin
            tbl_ip[i] = tbl_ip[i + 1];
            tbl_exp[i] = tbl_exp[i + 1];
        end
        tbl_cnt--;
    endfunction

    function automatic void place_sorted(logic [31:0] a, logic [31:0] e);
        int p;
        p = 0;
        while (p < tbl_cnt && !(e < tbl_exp[p]))
            p++;
        for (int i = tbl_cnt; i > p; i--)
        begin
            tbl_ip[i] = tbl_ip[i - 1];
            tbl_exp[i] = tbl_exp[i - 1];
        end
        tbl_ip[p] = a;
        tbl_exp[p] = e;
        tbl_cnt++;
    endfunction

    function automatic rsp_t blocklist_step(req_t r);
        rsp_t        o;
        int          idx;
        logic [31:0] stamp;
        logic [32:0] diff;
        o = '0;
        case (r.kind)
            KIND_ADD:
            begin
                stamp = (r.dur != 0) ? r.now + {1'b0, r.dur} : PERM_STAMP;
                idx = find_ip(r.ip);
                if (idx >= 0)
                begin
                    drop_at(idx);
                    place_sorted(r.ip, stamp);
                end
                else if (tbl_cnt >= DEPTH)
                    o.status = STATUS_FULL;
                else
                    place_sorted(r.ip, stamp);
            end
            KIND_REMOVE:
            begin
                idx = find_ip(r.ip);
                if (idx >= 0)
                    drop_at(idx);
                else
                    o.status = STATUS_NOTFOUND;
            end
            KIND_CHECK:
            begin
                idx = find_ip(r.ip);
                if (idx < 0)
                    o.status = STATUS_NOTFOUND;
                else
                begin
                    o.hit = 1;
                    if (tbl_exp[idx] == PERM_STAMP)
                        o.perm = 1;
                    else
                    begin
                        diff = {1'b0, tbl_exp[idx] - r.now} + ROUND_UP_SEC;
                        o.minutes = 27'(diff / SEC_PER_MIN);
                    end
                end
            end
            KIND_EXPIRE:
                while (tbl_cnt > 0 && tbl_exp[0] < r.now)
                    drop_at(0);
            KIND_GET:
                if (r.pos < tbl_cnt)
                begin
                    o.perm = (tbl_exp[r.pos] == PERM_STAMP);
                    o.eip = tbl_ip[r.pos];
                    o.eexp = tbl_exp[r.pos];
                    o.evalid = 1;
                end
                else
                    o.status = STATUS_NOTFOUND;
            default: ;
        endcase
        o.used = 7'(tbl_cnt);
        return o;
    endfunction

    task automatic send_request(req_t r, bit fixed, rsp_t want);
        rsp_t p;
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid <= 1;
        kind <= r.kind;
        ip_address <= r.ip;
        duration_seconds <= r.dur;
        now_seconds <= r.now;
        entry_position <= r.pos;
        do
            @(posedge clk);
        while (in_stall);
        p = blocklist_step(r);
        if (fixed && p != want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("directed row disagrees with predictor: table %h model %h", want, p);
        end
        expected_q.push_back(p);
        @(negedge clk);
    endtask

    function automatic req_t random_request(int mode);
        req_t r;
        int   c;
        r.ip = ($urandom_range(3) == 0) ? $urandom() : ip_pool[$urandom_range(7)];
        r.dur = ($urandom_range(9) == 0) ? 31'd0 :
                ($urandom_range(3) == 0) ? 31'($urandom()) : 31'($urandom_range(5000));
        r.now = ($urandom_range(15) == 0) ? $urandom() : 32'($urandom_range(10000));
        r.pos = 6'($urandom());
        c = $urandom_range(99);
        // Fill mode drives the table toward full; drain mode empties it.
        if (mode == 1)
            r.kind = (c < 70) ? KIND_ADD : (c < 80) ? KIND_CHECK : KIND_GET;
        else if (mode == 2)
            r.kind = (c < 40) ? KIND_REMOVE : (c < 60) ? KIND_EXPIRE : KIND_CHECK;
        else
            r.kind = (c < 30) ? KIND_ADD : (c < 45) ? KIND_REMOVE : (c < 65) ? KIND_CHECK :
                     (c < 75) ? KIND_EXPIRE : (c < 97) ? KIND_GET : 3'($urandom_range(7, 5));
        if (mode == 1 && $urandom_range(1))
            r.ip = $urandom();
        return r;
    endfunction

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_idle);

    always @(posedge clk)
    begin
        rsp_t got;
        rsp_t want;
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("tb_address_blocklist_with_expiry_unit: done, errors");
            $finish;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            got = {status, hit, minutes_left, is_permanent, entry_ip, entry_expiry,
                   entry_valid, entries_in_use};
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
            end
            else
            begin
                want = expected_q.pop_front();
                if (got != want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: status %0d/%0d hit %0d/%0d min %0d/%0d perm %0d/%0d ip %h/%h exp %h/%h ev %0d/%0d n %0d/%0d",
                                 want.status, got.status, want.hit, got.hit, want.minutes,
                                 got.minutes, want.perm, got.perm, want.eip, got.eip,
                                 want.eexp, got.eexp, want.evalid, got.evalid,
                                 want.used, got.used);
                end
            end
        end
    end

    initial
    begin
        row_t rows [$];
        row_t w;
        int   mode;
        for (int i = 0; i < 8; i++)
            ip_pool[i] = $urandom();
        ip_pool[0] = 32'h0;
        ip_pool[1] = 32'hffff_ffff;
        // kind, ip, dur, now, pos, fixed, expected
        rows = '{
            '{'{KIND_GET, 32'h0, 31'd0, 32'h0, 6'd0}, 1, '{STATUS_NOTFOUND, 0, 0, 0, 0, 0, 0, 0}},
            '{'{KIND_CHECK, 32'hffffffff, 31'd0, 32'h0, 6'd63}, 1,
              '{STATUS_NOTFOUND, 0, 0, 0, 0, 0, 0, 0}},
            '{'{KIND_REMOVE, 32'h1, 31'd0, 32'h0, 6'd0}, 1,
              '{STATUS_NOTFOUND, 0, 0, 0, 0, 0, 0, 0}},
            '{'{KIND_ADD, 32'hffffffff, 31'd0, 32'h5, 6'd0}, 1, '{STATUS_OK, 0, 0, 0, 0, 0, 0, 1}},
            '{'{KIND_CHECK, 32'hffffffff, 31'd7, 32'h5, 6'd0}, 1, '{STATUS_OK, 1, 0, 1, 0, 0, 0, 1}},
            '{'{KIND_ADD, 32'h0, 31'h7fffffff, 32'h80000000, 6'd0}, 0, '0},
            '{'{KIND_ADD, 32'h0a000001, 31'd1, 32'hffffffff, 6'd0}, 0, '0},
            '{'{KIND_ADD, 32'h0a000002, 31'd61, 32'd100, 6'd0}, 0, '0},
            '{'{KIND_ADD, 32'h0a000003, 31'd60, 32'd100, 6'd0}, 0, '0},
            '{'{KIND_CHECK, 32'h0a000002, 31'd0, 32'd100, 6'd0}, 0, '0},
            '{'{KIND_CHECK, 32'h0a000003, 31'd0, 32'd101, 6'd0}, 0, '0},
            '{'{KIND_CHECK, 32'h0a000003, 31'd0, 32'hffffffff, 6'd0}, 0, '0},
            '{'{KIND_ADD, 32'h0a000002, 31'd10, 32'd100, 6'd0}, 0, '0},
            '{'{KIND_GET, 32'h0, 31'd0, 32'h0, 6'd0}, 0, '0},
            '{'{KIND_GET, 32'h0, 31'd0, 32'h0, 6'd3}, 0, '0},
            '{'{KIND_GET, 32'h0, 31'd0, 32'h0, 6'd63}, 0, '0},
            '{'{KIND_ADD, 32'h0a000004, 31'h7fffffff, 32'hffffffff, 6'd0}, 0, '0},
            '{'{KIND_EXPIRE, 32'h0, 31'd0, 32'd105, 6'd0}, 0, '0},
            '{'{KIND_EXPIRE, 32'h0, 31'd0, 32'hffffffff, 6'd0}, 0, '0},
            '{'{KIND_REMOVE, 32'hffffffff, 31'd0, 32'h0, 6'd0}, 0, '0},
            '{'{3'd5, 32'h12345678, 31'd5, 32'd1, 6'd1}, 0, '0},
            '{'{3'd7, 32'hffffffff, 31'h7fffffff, 32'hffffffff, 6'h3f}, 0, '0},
            '{'{KIND_GET, 32'h0, 31'd0, 32'h0, 6'd1}, 0, '0}
        };
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;
        foreach (rows[i])
        begin
            w = rows[i];
            send_request(w.r, w.fixed, w.want);
        end
        for (int n = 0; n < 1550; n++)
        begin
            if (n == 520)
            begin
                send_idle = 72;
                recv_idle = 11;
            end
            if (n == 1040)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            // Phases of filling and draining let the full table be reached.
            mode = ((n % 260) < 90) ? 1 : ((n % 260) < 130) ? 2 : 0;
            send_request(random_request(mode), 0, '0);
        end
        in_valid <= 0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("tb_address_blocklist_with_expiry_unit: done, clean");
        else
            $display("tb_address_blocklist_with_expiry_unit: done, errors");
        $finish;
    end
endmodule
